FILE: rtl/core/mmc_pkg.sv
// Shared types and constants of the mouse motion coalescer.
package mmc_pkg;

  // Default parameter values
  localparam int ACCUM_WIDTH_DEF = 16;
  localparam int TIME_WIDTH_DEF  = 32;

  // Fixed field widths
  localparam int NOW_W      = 32;
  localparam int DELTA_W    = 8;
  localparam int NUM_BTN    = 3;
  localparam int MAX_EV     = 4;
  localparam int CNT_W      = 3;
  localparam int EV_IDX_W   = 2;
  localparam int BTN_ID_W   = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;

  // Register reset values and move clamp limit
  localparam logic [CFG_DATA_W-1:0] INTERVAL_RESET = 8'd8;
  localparam int                    MOVE_LIMIT     = 127;

  typedef enum logic [0:0] {
    KIND_REPORT    = 1'b0,
    KIND_LINK_DOWN = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    EV_PRESS   = 2'd0,
    EV_RELEASE = 2'd1,
    EV_MOVE    = 2'd2
  } ev_kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ENABLE   = 1'b0,
    REG_INTERVAL = 1'b1
  } cfg_idx_t;

  // One accepted report transaction
  typedef struct packed {
    kind_t                      kind;
    logic [NUM_BTN-1:0]         buttons;
    logic signed [DELTA_W-1:0]  delta_x;
    logic signed [DELTA_W-1:0]  delta_y;
    logic signed [DELTA_W-1:0]  delta_wheel;
    logic [NOW_W-1:0]           now_ms;
    logic                       link_up;
  } rpt_item_t;

  // One outgoing event
  typedef struct packed {
    ev_kind_t                   kind;
    logic [BTN_ID_W-1:0]        button_id;
    logic signed [DELTA_W-1:0]  move_x;
    logic signed [DELTA_W-1:0]  move_y;
    logic signed [DELTA_W-1:0]  move_wheel;
  } evt_t;

  // All events caused by one report, in emission order
  typedef struct packed {
    logic [CNT_W-1:0]   count;
    evt_t [MAX_EV-1:0]  ev;
  } bundle_t;

endpackage

FILE: rtl/core/mmc_if.sv
// Report and event channel interfaces of the mouse motion coalescer.
interface mmc_rpt_if;
  logic                              valid;
  logic                              ready;
  mmc_pkg::kind_t                    kind;
  logic [mmc_pkg::NUM_BTN-1:0]       buttons;
  logic signed [mmc_pkg::DELTA_W-1:0] delta_x;
  logic signed [mmc_pkg::DELTA_W-1:0] delta_y;
  logic signed [mmc_pkg::DELTA_W-1:0] delta_wheel;
  logic [mmc_pkg::NOW_W-1:0]         now_ms;
  logic                              link_up;

  modport source (output valid, kind, buttons, delta_x, delta_y, delta_wheel, now_ms, link_up,
                  input ready);
  modport sink (input valid, kind, buttons, delta_x, delta_y, delta_wheel, now_ms, link_up,
                output ready);
endinterface

interface mmc_evt_if;
  logic                               valid;
  logic                               ready;
  mmc_pkg::ev_kind_t                  event_kind;
  logic [mmc_pkg::BTN_ID_W-1:0]       button_id;
  logic signed [mmc_pkg::DELTA_W-1:0] move_x;
  logic signed [mmc_pkg::DELTA_W-1:0] move_y;
  logic signed [mmc_pkg::DELTA_W-1:0] move_wheel;
  logic                               last;

  modport source (output valid, event_kind, button_id, move_x, move_y, move_wheel, last,
                  input ready);
  modport sink (input valid, event_kind, button_id, move_x, move_y, move_wheel, last,
                output ready);
endinterface

FILE: rtl/core/mmc_eval.sv
// Report evaluation: button diffing, saturating accumulators and move decision.
module mmc_eval #(
  parameter int ACCUM_WIDTH = mmc_pkg::ACCUM_WIDTH_DEF,
  parameter int TIME_WIDTH  = mmc_pkg::TIME_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                enable,
  input  logic [mmc_pkg::CFG_DATA_W-1:0]      report_interval,
  input  mmc_pkg::rpt_item_t                  item,
  input  logic                                fire,
  output mmc_pkg::bundle_t                    bundle
);

  localparam int DW = mmc_pkg::DELTA_W;
  localparam logic signed [ACCUM_WIDTH-1:0] ACC_MAX = {1'b0, {(ACCUM_WIDTH-1){1'b1}}};
  localparam logic signed [ACCUM_WIDTH-1:0] ACC_MIN = {1'b1, {(ACCUM_WIDTH-1){1'b0}}};
  localparam logic signed [ACCUM_WIDTH-1:0] LIM_POS = ACCUM_WIDTH'(mmc_pkg::MOVE_LIMIT);
  localparam logic signed [ACCUM_WIDTH-1:0] LIM_NEG = -LIM_POS;

  logic [mmc_pkg::NUM_BTN-1:0]   prev_buttons;
  logic signed [ACCUM_WIDTH-1:0] pending_x;
  logic signed [ACCUM_WIDTH-1:0] pending_y;
  logic signed [ACCUM_WIDTH-1:0] pending_wheel;
  logic [TIME_WIDTH-1:0]         last_move_time;

  logic                          active;
  logic                          clear;
  logic                          move;
  logic                          due;
  logic [TIME_WIDTH-1:0]         now_t;
  logic [mmc_pkg::NUM_BTN-1:0]   changed;
  logic signed [ACCUM_WIDTH-1:0] sum_x, sum_y, sum_w;
  logic signed [DW-1:0]          send_x, send_y, send_w;

  // Saturating add of an 8-bit delta into an accumulator
  function automatic logic signed [ACCUM_WIDTH-1:0] sat_add(
    input logic signed [ACCUM_WIDTH-1:0] acc,
    input logic signed [DW-1:0]          d
  );
    logic signed [ACCUM_WIDTH:0] s;
    s = {acc[ACCUM_WIDTH-1], acc} + {{(ACCUM_WIDTH+1-DW){d[DW-1]}}, d};
    if (s[ACCUM_WIDTH] != s[ACCUM_WIDTH-1]) begin
      return s[ACCUM_WIDTH] ? ACC_MIN : ACC_MAX;
    end
    return s[ACCUM_WIDTH-1:0];
  endfunction

  // Clamp an accumulator to the move range
  function automatic logic signed [DW-1:0] clamp(input logic signed [ACCUM_WIDTH-1:0] v);
    if (v > LIM_POS) return LIM_POS[DW-1:0];
    if (v < LIM_NEG) return LIM_NEG[DW-1:0];
    return v[DW-1:0];
  endfunction

  // Decode what the item does
  assign active  = enable && (item.kind == mmc_pkg::KIND_REPORT) && item.link_up;
  assign clear   = enable && (item.kind == mmc_pkg::KIND_LINK_DOWN);
  assign changed = item.buttons ^ prev_buttons;

  // Accumulate and decide on a move
  assign sum_x  = sat_add(pending_x, item.delta_x);
  assign sum_y  = sat_add(pending_y, item.delta_y);
  assign sum_w  = sat_add(pending_wheel, item.delta_wheel);
  assign send_x = clamp(sum_x);
  assign send_y = clamp(sum_y);
  assign send_w = clamp(sum_w);
  assign now_t  = TIME_WIDTH'(item.now_ms);
  assign due    = (now_t - last_move_time) >= TIME_WIDTH'(report_interval);
  assign move   = active && due && ((sum_x != '0) || (sum_y != '0) || (sum_w != '0));

  // Assemble events: changed buttons in order, then the move
  always_comb begin
    logic [mmc_pkg::CNT_W-1:0] n;
    n = '0;
    bundle = '0;
    for (int b = 0; b < mmc_pkg::NUM_BTN; b++) begin
      if (changed[b]) begin
        bundle.ev[n[mmc_pkg::EV_IDX_W-1:0]].kind =
          item.buttons[b] ? mmc_pkg::EV_PRESS : mmc_pkg::EV_RELEASE;
        bundle.ev[n[mmc_pkg::EV_IDX_W-1:0]].button_id = mmc_pkg::BTN_ID_W'(b);
        n = n + 1'b1;
      end
    end
    if (move) begin
      bundle.ev[n[mmc_pkg::EV_IDX_W-1:0]].kind       = mmc_pkg::EV_MOVE;
      bundle.ev[n[mmc_pkg::EV_IDX_W-1:0]].move_x     = send_x;
      bundle.ev[n[mmc_pkg::EV_IDX_W-1:0]].move_y     = send_y;
      bundle.ev[n[mmc_pkg::EV_IDX_W-1:0]].move_wheel = send_w;
      n = n + 1'b1;
    end
    bundle.count = active ? n : '0;
  end

  // State update when the item is consumed
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_buttons   <= '0;
      pending_x      <= '0;
      pending_y      <= '0;
      pending_wheel  <= '0;
      last_move_time <= '0;
    end else if (fire) begin
      if (clear) begin
        prev_buttons  <= '0;
        pending_x     <= '0;
        pending_y     <= '0;
        pending_wheel <= '0;
      end else if (active) begin
        prev_buttons <= item.buttons;
        if (move) begin
          pending_x      <= sum_x - {{(ACCUM_WIDTH-DW){send_x[DW-1]}}, send_x};
          pending_y      <= sum_y - {{(ACCUM_WIDTH-DW){send_y[DW-1]}}, send_y};
          pending_wheel  <= sum_w - {{(ACCUM_WIDTH-DW){send_w[DW-1]}}, send_w};
          last_move_time <= now_t;
        end else begin
          pending_x     <= sum_x;
          pending_y     <= sum_y;
          pending_wheel <= sum_w;
        end
      end
    end
  end

endmodule

FILE: rtl/core/mmc_evq.sv
// Result register for one report's events, sent one per cycle while evt.ready.
module mmc_evq (
  input  logic               clk,
  input  logic               rst,
  input  mmc_pkg::bundle_t   bundle,
  input  logic               load,
  output logic               free,
  mmc_evt_if.source          evt
);

  mmc_pkg::bundle_t                  held;
  logic                              held_valid;
  logic [mmc_pkg::EV_IDX_W-1:0]      idx;
  logic                              is_last;
  mmc_pkg::evt_t                     cur;

  assign cur     = held.ev[idx];
  assign is_last = ({1'b0, idx} == (held.count - 1'b1));
  assign free    = !held_valid || (evt.ready && is_last);

  // Drive the event channel
  assign evt.valid      = held_valid;
  assign evt.event_kind = cur.kind;
  assign evt.button_id  = cur.button_id;
  assign evt.move_x     = cur.move_x;
  assign evt.move_y     = cur.move_y;
  assign evt.move_wheel = cur.move_wheel;
  assign evt.last       = is_last;

  // Payload load, no reset needed
  always_ff @(posedge clk) begin
    if (load) begin
      held <= bundle;
    end
  end

  // Control: valid flag and event pointer
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
      idx        <= '0;
    end else if (load) begin
      held_valid <= 1'b1;
      idx        <= '0;
    end else if (held_valid && evt.ready) begin
      if (is_last) begin
        held_valid <= 1'b0;
      end else begin
        idx <= idx + 1'b1;
      end
    end
  end

endmodule

FILE: rtl/core/mouse_motion_coalescer_core.sv
// A report goes through the report register, then the event register, which is
// the limiting unit; the report register refills meanwhile. One report per cycle
// when each yields at most one event and the event channel is ready; a report
// yielding more holds the event register, sending one event per ready cycle.
// Reset (synchronous, active high): block disabled, interval 8 ms, buttons,
// accumulators and last move time cleared, both channel registers empty.
module mouse_motion_coalescer_core #(
  parameter int ACCUM_WIDTH = mmc_pkg::ACCUM_WIDTH_DEF,
  parameter int TIME_WIDTH  = mmc_pkg::TIME_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [mmc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mmc_pkg::CFG_DATA_W-1:0]    cfg_data,
  mmc_rpt_if.sink                           rpt,
  mmc_evt_if.source                         evt
);

  logic                               enable;
  logic [mmc_pkg::CFG_DATA_W-1:0]     report_interval;
  mmc_pkg::rpt_item_t                 item;
  logic                               item_valid;
  logic                               consume;
  logic                               load;
  logic                               free;
  mmc_pkg::bundle_t                   bundle;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      enable          <= 1'b0;
      report_interval <= mmc_pkg::INTERVAL_RESET;
    end else if (cfg_we) begin
      unique case (mmc_pkg::cfg_idx_t'(cfg_index))
        mmc_pkg::REG_ENABLE:   enable          <= cfg_data[0];
        mmc_pkg::REG_INTERVAL: report_interval <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register: consumed once its events fit in the event register
  assign consume   = item_valid && ((bundle.count == '0) || free);
  assign load      = consume && (bundle.count != '0);
  assign rpt.ready = !item_valid || consume;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (rpt.valid && rpt.ready) begin
      item_valid <= 1'b1;
    end else if (consume) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rpt.valid && rpt.ready) begin
      item.kind        <= rpt.kind;
      item.buttons     <= rpt.buttons;
      item.delta_x     <= rpt.delta_x;
      item.delta_y     <= rpt.delta_y;
      item.delta_wheel <= rpt.delta_wheel;
      item.now_ms      <= rpt.now_ms;
      item.link_up     <= rpt.link_up;
    end
  end

  mmc_eval #(
    .ACCUM_WIDTH (ACCUM_WIDTH),
    .TIME_WIDTH  (TIME_WIDTH)
  ) u_eval (
    .clk             (clk),
    .rst             (rst),
    .enable          (enable),
    .report_interval (report_interval),
    .item            (item),
    .fire            (consume),
    .bundle          (bundle)
  );

  mmc_evq u_evq (
    .clk    (clk),
    .rst    (rst),
    .bundle (bundle),
    .load   (load),
    .free   (free),
    .evt    (evt)
  );

  // An event transaction that is not the last keeps the channel valid
  a_burst_continues: assert property (@(posedge clk) disable iff (rst)
    evt.valid && evt.ready && !evt.last |=> evt.valid)
    else $error("event burst broke off before its last transaction");

  // Button events carry no movement
  a_button_no_move: assert property (@(posedge clk) disable iff (rst)
    evt.valid && (evt.event_kind != mmc_pkg::EV_MOVE) |->
      (evt.move_x == '0) && (evt.move_y == '0) && (evt.move_wheel == '0))
    else $error("button event carries movement");

  // Stalled report register means a held item waits on the event register
  a_stall_reason: assert property (@(posedge clk) disable iff (rst)
    !rpt.ready |-> item_valid && !free && (bundle.count != '0))
    else $error("report channel stalled without cause");

endmodule
